/* hw/rtl/mfde_pkg.sv */
// Shared codes, constants and the 5x8 font table of the framebuffer draw engine.
package mfde_pkg;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PIXEL = 3'd1;
  localparam logic [2:0] OP_RECT  = 3'd2;
  localparam logic [2:0] OP_GLYPH = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [7:0] GLYPH_FIRST = 8'h20;
  localparam logic [7:0] GLYPH_LAST  = 8'h7E;
  localparam logic [8:0] GLYPH_PITCH = 9'd6;
  localparam logic [2:0] GLYPH_COLS  = 3'd5;

  // one entry per printable code, five column bytes, leftmost column first
  typedef logic [0:94][0:4][7:0] glyph_rom_t;

  localparam glyph_rom_t GLYPH_ROM = {
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
    40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
    40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
    40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
    40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
    40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E4141497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0003070800, 40'h2054545478, 40'h7F28444438, 40'h3844444428,
    40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
    40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
    40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
    40'h0000770000, 40'h0041360800, 40'h0201020402
  };

endpackage

/* hw/rtl/mfde_store.sv */
// Frame store: single-port byte RAM with registered read data.
module mfde_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/mono_framebuffer_draw_engine_core.sv */
// Top level of the monochrome page framebuffer draw engine.
//
//  channel | dir | words                         | handshake
//  in_     | in  | one draw/read command         | in_tvalid / in_tready
//  out_    | out | one read-back byte per read   | out_tvalid / out_tready
//
// A command is captured and decoded first; then a pixel or rectangle reads and
// rewrites each touched page byte, a glyph writes five ink columns and a blank
// one, a read fetches one store byte (none when out of range), and a clear
// sweeps every byte. The single-port store (one access a cycle) and the byte
// read-modify-write shape these steps. After reset the store is swept to zero
// with in_tready low. A read result waits in its output register; a further
// read stalls only if that register is full.
module mono_framebuffer_draw_engine_core #(
  parameter int WIDTH_PIXELS = 128,
  parameter int PAGE_COUNT   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], x_pos[10:3], y_pos[18:11], rect_width[26:19],
  // rect_height[34:27], pixel_on[35], page_row[43:36], char_code[51:44], zero
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0], addr_ok[8], zero
  output logic [15:0] out_tdata
);
  import mfde_pkg::*;

  localparam int STORE_BYTES = PAGE_COUNT * WIDTH_PIXELS;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CW = $clog2(WIDTH_PIXELS);
  localparam logic [8:0] W9    = 9'(WIDTH_PIXELS);
  localparam logic [8:0] ROWS9 = 9'(PAGE_COUNT * 8);
  localparam logic [8:0] PC9   = 9'(PAGE_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SETUP    = 3'd2;
  localparam logic [2:0] S_RECT_RD  = 3'd3;
  localparam logic [2:0] S_RECT_WR  = 3'd4;
  localparam logic [2:0] S_GLYPH    = 3'd5;
  localparam logic [2:0] S_READ_RD  = 3'd6;
  localparam logic [2:0] S_READ_CAP = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    op_r;
  logic [7:0]    x_r, y_r, w_r, h_r, pin_r, code_r;
  logic          on_r;
  logic [PW-1:0] page_r, page_nxt, pend_r, pend_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [8:0]    xend_r, xend_nxt, yend_r, yend_nxt;
  logic [6:0]    gidx_r, gidx_nxt;
  logic [2:0]    gcol_r, gcol_nxt;
  logic          ok_r, ok_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_ok_r, out_ok_nxt;

  logic          in_acc;
  logic [7:0]    wv, hv;
  logic [8:0]    xsum, ysum, xend, yend, yend_m1;
  logic          rect_empty, glyph_ok, read_ok, printable;
  logic [7:0]    mask;
  logic [8:0]    row9;
  logic [AW-1:0] addr_calc, mem_addr;
  logic          mem_we, mem_re;
  logic [7:0]    mem_wdata, mem_q, glyph_byte;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // decode of the captured command
  always_comb begin
    wv = (op_r == OP_PIXEL) ? 8'd1 : w_r;
    hv = (op_r == OP_PIXEL) ? 8'd1 : h_r;
    xsum = {1'b0, x_r} + {1'b0, wv};
    ysum = {1'b0, y_r} + {1'b0, hv};
    xend = (xsum < W9) ? xsum : W9;
    yend = (ysum < ROWS9) ? ysum : ROWS9;
    yend_m1 = yend - 9'd1;
    rect_empty = ({1'b0, x_r} >= xend) || ({1'b0, y_r} >= yend);
    glyph_ok = ({1'b0, pin_r} < PC9) && (({1'b0, x_r} + GLYPH_PITCH) <= W9);
    read_ok = ({1'b0, pin_r} < PC9) && ({1'b0, x_r} < W9);
    printable = (code_r >= GLYPH_FIRST) && (code_r <= GLYPH_LAST);
  end

  // rows of the current page that fall inside the rectangle
  always_comb begin
    mask = '0;
    row9 = '0;
    for (int b = 0; b < 8; b++) begin
      row9 = 9'({page_r, 3'(b)});
      mask[b] = (row9 >= {1'b0, y_r}) && (row9 < yend_r);
    end
  end

  assign addr_calc  = AW'(page_r) * AW'(WIDTH_PIXELS) + AW'(col_r);
  assign glyph_byte = (gcol_r < GLYPH_COLS) ? GLYPH_ROM[gidx_r][gcol_r] : 8'h00;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_calc;
    mem_wdata = 8'h00;
    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
      end
      S_RECT_RD, S_READ_RD: mem_re = 1'b1;
      S_RECT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = on_r ? (mem_q | mask) : (mem_q & ~mask);
      end
      S_GLYPH: begin
        mem_we    = 1'b1;
        mem_wdata = glyph_byte;
      end
      default: ;
    endcase
  end

  mfde_store #(
    .DEPTH(STORE_BYTES),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_q)
  );

  always_comb begin
    state_nxt     = state_r;
    page_nxt      = page_r;
    pend_nxt      = pend_r;
    col_nxt       = col_r;
    xend_nxt      = xend_r;
    yend_nxt      = yend_r;
    gidx_nxt      = gidx_r;
    gcol_nxt      = gcol_r;
    ok_nxt        = ok_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_ok_nxt    = out_ok_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        state_nxt = S_IDLE;
        unique case (op_r)
          OP_CLEAR: begin
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end
          OP_PIXEL, OP_RECT: begin
            page_nxt = y_r[3 +: PW];
            pend_nxt = yend_m1[3 +: PW];
            col_nxt  = x_r[CW-1:0];
            xend_nxt = xend;
            yend_nxt = yend;
            if (!rect_empty) begin
              state_nxt = S_RECT_RD;
            end
          end
          OP_GLYPH: begin
            page_nxt = pin_r[PW-1:0];
            col_nxt  = x_r[CW-1:0];
            gcol_nxt = '0;
            gidx_nxt = printable ? 7'(code_r - GLYPH_FIRST) : 7'd0;
            if (glyph_ok) begin
              state_nxt = S_GLYPH;
            end
          end
          OP_READ: begin
            page_nxt  = pin_r[PW-1:0];
            col_nxt   = x_r[CW-1:0];
            ok_nxt    = read_ok;
            state_nxt = read_ok ? S_READ_RD : S_READ_CAP;
          end
          default: ;
        endcase
      end
      S_RECT_RD: state_nxt = S_RECT_WR;
      S_RECT_WR: begin
        state_nxt = S_RECT_RD;
        if ((9'(col_r) + 9'd1) == xend_r) begin
          col_nxt = x_r[CW-1:0];
          if (page_r == pend_r) begin
            state_nxt = S_IDLE;
          end else begin
            page_nxt = page_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_GLYPH: begin
        col_nxt  = col_r + 1'b1;
        gcol_nxt = gcol_r + 3'd1;
        if (gcol_r == GLYPH_COLS) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ_RD: state_nxt = S_READ_CAP;
      S_READ_CAP: begin
        // hold the read byte until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ok_r ? mem_q : 8'h00;
          out_ok_nxt    = ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tdata[2:0];
      x_r    <= in_tdata[10:3];
      y_r    <= in_tdata[18:11];
      w_r    <= in_tdata[26:19];
      h_r    <= in_tdata[34:27];
      on_r   <= in_tdata[35];
      pin_r  <= in_tdata[43:36];
      code_r <= in_tdata[51:44];
    end
    page_r     <= page_nxt;
    pend_r     <= pend_nxt;
    col_r      <= col_nxt;
    xend_r     <= xend_nxt;
    yend_r     <= yend_nxt;
    gidx_r     <= gidx_nxt;
    gcol_r     <= gcol_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_ok_r, out_data_r};

endmodule

/* hw/rtl/mfde_checker.sv */
// Port-level checks on the draw engine, bound to its top level.
module mfde_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // in_tready is low right after every accepted command word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high right after an accepted word");

  // an out-of-range read always returns a zero byte
  a_bad_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[8]) |-> (out_tdata[7:0] == 8'h00))
    else $error("read byte not zero with addr_ok low");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:9] == 7'd0))
    else $error("out_tdata padding not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output word changed");

endmodule

bind mono_framebuffer_draw_engine_core mfde_checker u_mfde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the framebuffer draw engine: draw commands with read-back checks.
module tb_top;
  import mfde_pkg::*;

  localparam int FB_COLS        = 128;
  localparam int FB_PAGES       = 8;
  localparam int FB_ROWS        = FB_PAGES * 8;
  localparam int FB_BYTES       = FB_PAGES * FB_COLS;
  localparam int GLYPH_W        = 6;
  localparam int GLYPH_INK      = 5;
  localparam int WATCHDOG_LIMIT = 20000;
  // worst case behind the last read: a full-screen rectangle
  localparam int DRAIN_CYCLES   = 2 * FB_BYTES + 32;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // 5 column bytes per printable code, leftmost column in the top byte
  localparam logic [0:94][39:0] FONT_COLS = {
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
    40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
    40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
    40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
    40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
    40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E4141497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0003070800, 40'h2054545478, 40'h7F28444438, 40'h3844444428,
    40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
    40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
    40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
    40'h0000770000, 40'h0041360800, 40'h0201020402
  };

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       pixel_on;
    logic [7:0] page_row;
    logic [7:0] char_code;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       addr_ok;
  } fb_byte_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  logic [7:0]  shadow_fb [0:FB_BYTES-1];
  fb_byte_t    pending_reads [$];
  fb_byte_t    want;
  int          err_count    = 0;
  int          quiet_cycles = 0;
  int          sink_hold    = 0;
  bit          src_gaps     = 1'b1;
  bit          sink_gaps    = 1'b1;

  mono_framebuffer_draw_engine_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------- shadow framebuffer ----------------

  function automatic void wipe_shadow();
    int i;
    for (i = 0; i < FB_BYTES; i++) shadow_fb[i] = '0;
  endfunction

  function automatic void plot_shadow(int px, int py, logic on);
    int idx;
    if (px >= FB_COLS || py >= FB_ROWS) return;
    idx = (py / 8) * FB_COLS + px;
    shadow_fb[idx][py % 8] = on;
  endfunction

  function automatic void predict_cmd(draw_cmd_t c);
    int x_end, y_end, row, col, base, glyph_idx;
    fb_byte_t r;
    case (c.opcode)
      OP_CLEAR: wipe_shadow();
      OP_PIXEL: plot_shadow(int'(c.x_pos), int'(c.y_pos), c.pixel_on);
      OP_RECT: begin
        x_end = int'(c.x_pos) + int'(c.rect_width);
        y_end = int'(c.y_pos) + int'(c.rect_height);
        if (x_end > FB_COLS) x_end = FB_COLS;
        if (y_end > FB_ROWS) y_end = FB_ROWS;
        for (row = int'(c.y_pos); row < y_end; row++)
          for (col = int'(c.x_pos); col < x_end; col++)
            plot_shadow(col, row, c.pixel_on);
      end
      OP_GLYPH: begin
        if (int'(c.page_row) < FB_PAGES && int'(c.x_pos) + GLYPH_W <= FB_COLS) begin
          // anything outside the printable range becomes a space
          if (c.char_code < GLYPH_FIRST || c.char_code > GLYPH_LAST) glyph_idx = 0;
          else glyph_idx = int'(c.char_code) - int'(GLYPH_FIRST);
          base = int'(c.page_row) * FB_COLS + int'(c.x_pos);
          for (col = 0; col < GLYPH_INK; col++)
            shadow_fb[base + col] = FONT_COLS[glyph_idx][39 - 8 * col -: 8];
          shadow_fb[base + GLYPH_INK] = '0;
        end
      end
      OP_READ: begin
        if (int'(c.page_row) < FB_PAGES && int'(c.x_pos) < FB_COLS) begin
          r.read_data = shadow_fb[int'(c.page_row) * FB_COLS + int'(c.x_pos)];
          r.addr_ok   = 1'b1;
        end else begin
          r.read_data = '0;
          r.addr_ok   = 1'b0;
        end
        pending_reads.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------- stimulus ----------------

  function automatic draw_cmd_t mk_cmd(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                       logic [7:0] w, logic [7:0] h, logic on,
                                       logic [7:0] page, logic [7:0] code);
    draw_cmd_t c;
    c.opcode      = op;
    c.x_pos       = x;
    c.y_pos       = y;
    c.rect_width  = w;
    c.rect_height = h;
    c.pixel_on    = on;
    c.page_row    = page;
    c.char_code   = code;
    return c;
  endfunction

  function automatic draw_cmd_t noisy_cmd();
    return mk_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic push_cmd(input draw_cmd_t c);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, c.char_code, c.page_row, c.pixel_on, c.rect_height,
                  c.rect_width, c.y_pos, c.x_pos, c.opcode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_cmd(c);
  endtask

  task automatic read_byte(input logic [7:0] page, input logic [7:0] x);
    push_cmd(mk_cmd(OP_READ, x, 8'd0, 8'd0, 8'd0, 1'b0, page, 8'd0));
  endtask

  task automatic test_power_up_read();
    read_byte(8'd7, 8'd127);
    read_byte(8'd0, 8'd0);
  endtask

  task automatic test_pixel_edges();
    push_cmd(mk_cmd(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
    push_cmd(mk_cmd(OP_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
    // off screen: both must be dropped
    push_cmd(mk_cmd(OP_PIXEL, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
    push_cmd(mk_cmd(OP_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
    read_byte(8'd0, 8'd0);
    read_byte(8'd7, 8'd127);
  endtask

  task automatic test_rect_clipping();
    push_cmd(mk_cmd(OP_RECT, 8'd120, 8'd60, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0));
    push_cmd(mk_cmd(OP_RECT, 8'd10, 8'd10, 8'd0, 8'd5, 1'b1, 8'd0, 8'd0));
    push_cmd(mk_cmd(OP_RECT, 8'd10, 8'd10, 8'd5, 8'd0, 1'b1, 8'd0, 8'd0));
    push_cmd(mk_cmd(OP_RECT, 8'd200, 8'd70, 8'd20, 8'd20, 1'b1, 8'd0, 8'd0));
    // one-pixel-high line, then knock a hole in the clipped block
    push_cmd(mk_cmd(OP_RECT, 8'd100, 8'd61, 8'd30, 8'd1, 1'b1, 8'd0, 8'd0));
    push_cmd(mk_cmd(OP_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    read_byte(8'd7, 8'd120);
    read_byte(8'd7, 8'd127);
    read_byte(8'd7, 8'd100);
  endtask

  task automatic test_glyph_cases();
    push_cmd(mk_cmd(OP_GLYPH, 8'd122, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'h41));
    push_cmd(mk_cmd(OP_GLYPH, 8'd123, 8'd0, 8'd0, 8'd0, 1'b0, 8'd1, 8'h41));
    push_cmd(mk_cmd(OP_GLYPH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd8, 8'h41));
    push_cmd(mk_cmd(OP_GLYPH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'hFF));
    push_cmd(mk_cmd(OP_GLYPH, 8'd6, 8'd0, 8'd0, 8'd0, 1'b0, 8'd7, 8'h7E));
    push_cmd(mk_cmd(OP_GLYPH, 8'd12, 8'd0, 8'd0, 8'd0, 1'b0, 8'd7, 8'h7F));
    push_cmd(mk_cmd(OP_GLYPH, 8'd18, 8'd0, 8'd0, 8'd0, 1'b0, 8'd255, 8'h20));
    read_byte(8'd0, 8'd0);
    read_byte(8'd0, 8'd123);
    read_byte(8'd7, 8'd8);
  endtask

  task automatic test_spare_ops_and_clear();
    logic [2:0] op;
    for (op = OP_SPARE_LO; op <= OP_SPARE_HI && op >= OP_SPARE_LO; op++) begin
      push_cmd(mk_cmd(op, 8'd5, 8'd5, 8'd9, 8'd9, 1'b1, 8'd0, 8'h41));
    end
    read_byte(8'd8, 8'd0);
    read_byte(8'd0, 8'd128);
    push_cmd(mk_cmd(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    read_byte(8'd7, 8'd120);
  endtask

  // mostly draw-then-read-back runs in a busy corner, with some raw noise
  task automatic test_random_draws(input int n_items);
    draw_cmd_t c;
    int sent, n_reads, k, anchor_x, anchor_page;
    sent = 0;
    while (sent < n_items) begin
      c = noisy_cmd();
      k = $urandom_range(0, 99);
      if (k < 15) begin
        // clears are slow, keep them rare
        if (c.opcode == OP_CLEAR && $urandom_range(0, 7) != 0) c.opcode = OP_READ;
        push_cmd(c);
        if (c.opcode <= OP_READ) sent++;
      end else begin
        c.opcode = (k < 40) ? OP_PIXEL : (k < 65) ? OP_RECT : OP_GLYPH;
        if ($urandom_range(0, 7) == 0) begin
          c.x_pos    = 8'($urandom_range(0, FB_COLS - 1));
          c.y_pos    = 8'($urandom_range(0, FB_ROWS - 1));
          c.page_row = 8'($urandom_range(0, FB_PAGES - 1));
        end else begin
          c.x_pos    = 8'($urandom_range(0, 47));
          c.y_pos    = 8'($urandom_range(0, 31));
          c.page_row = 8'($urandom_range(0, 3));
        end
        c.rect_width  = 8'($urandom_range(0, 12));
        c.rect_height = 8'($urandom_range(0, 12));
        push_cmd(c);
        anchor_x    = int'(c.x_pos);
        anchor_page = (c.opcode == OP_GLYPH) ? int'(c.page_row) : int'(c.y_pos) / 8;
        n_reads = $urandom_range(1, 3);
        repeat (n_reads) begin
          read_byte(8'(anchor_page + int'($urandom_range(0, 1))),
                    8'(anchor_x + int'($urandom_range(0, 7))));
        end
        sent += 1 + n_reads;
      end
    end
  endtask

  // ---------------- result side ----------------

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
      sink_hold  <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reads.size() == 0) begin
        err_count++;
        $error("read-back word with none pending: read_data=%0h addr_ok=%0b",
               out_tdata[7:0], out_tdata[8]);
      end else begin
        want = pending_reads.pop_front();
        if (out_tdata[7:0] !== want.read_data) begin
          err_count++;
          $error("read_data: expected %0h, got %0h", want.read_data, out_tdata[7:0]);
        end
        if (out_tdata[8] !== want.addr_ok) begin
          err_count++;
          $error("addr_ok: expected %0b, got %0b", want.addr_ok, out_tdata[8]);
        end
      end
    end
  end

  // counts cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    wipe_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_power_up_read();
    test_pixel_edges();
    test_rect_clipping();
    test_glyph_cases();
    test_spare_ops_and_clear();
    test_random_draws(750);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random_draws(150);
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mfde_pkg.sv
hw/rtl/mfde_store.sv
hw/rtl/mono_framebuffer_draw_engine_core.sv
hw/rtl/mfde_checker.sv
dv/tb_top.sv
